/* src/timeout_table_macros.svh */
// assertion macros for the timeout table
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TIMEOUT_TABLE_MACROS_SVH
`define TIMEOUT_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define TT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define TT_ASSERT(lbl, prop, msg)
`define TT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* src/tt_pkg.sv */
// command and status codes for the timeout table
// no dependencies
package tt_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_FIRED    = 3'd4,
    STAT_NONE_DUE = 3'd5
  } status_e;

endpackage

/* src/timeout_table.sv */
// timeout table: timer slots with deadlines, walked newest first by one comparator.
// a command enters on the slave stream, one or more results leave on the master stream.
// the block is ready only between commands. an add, delete or check is a transfer
// carrying cmd in tuser and the operands in tdata. an add answers with the handle
// it allocated or a full status; a delete answers deleted or absent; a check gives
// one fired result per due timer, newest first, or one none-due result. tlast
// marks the final result of a command.
// an add scans the slots from the lowest, stepping over each occupied slot below
// the free one; an add to a full table goes straight to its result. a delete or
// check visits each live timer in turn, reading the order memory, then the deadline
// memory, then comparing. unused command 3 is taken and gives no result.
// results go through an output register: a stalled receiver holds the block only
// when a further result must be written; a new command may be taken while the
// last result is still waiting. reset empties the table at once, no clearing pass.
`include "timeout_table_macros.svh"

module timeout_table
  import tt_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // now_time[31:0], delay[62:32], repeat_mark[63],
                                      // handle_in[67:64], zero fill above
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // handle_out[3:0], zero fill above
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast
);

  localparam int SB = $clog2(SLOTS);
  localparam int CB = $clog2(SLOTS + 1);
  localparam int SW = (TIME_BITS > 32) ? TIME_BITS + 1 : 34;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_ORD_RD = 6'b000100,
    ST_DL_RD  = 6'b001000,
    ST_EVAL   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  function automatic logic [SB-1:0] wrap_add(logic [SB-1:0] b, logic [SB-1:0] i);
    logic [SB:0] s;
    s = {1'b0, b} + {1'b0, i};
    if (s >= (SB+1)'(SLOTS)) s = s - (SB+1)'(SLOTS);
    return s[SB-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [1:0]           cmd_q;
  logic [TIME_BITS-1:0] now_q;
  logic [30:0]          delay_q;
  logic                 rep_q;
  logic [3:0]           hin_q;
  logic [CB-1:0]        live_q, live_d;
  logic [SLOTS-1:0]     slot_live_q, slot_live_d;
  logic [SB-1:0]        base_q, base_d;
  logic [CB-1:0]        rd_q, rd_d, wr_q, wr_d;
  logic [SB-1:0]        scan_q, scan_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [SB-1:0]        pend_slot_q, pend_slot_d;
  status_e              fin_status_q, fin_status_d;
  logic [3:0]           fin_handle_q, fin_handle_d;

  logic                 out_valid_q, out_last_q, out_load, out_last_d;
  status_e              out_status_q, out_status_d;
  logic [3:0]           out_handle_q, out_handle_d;
  logic                 out_free;

  // order list memory: logical position p lives at base + p
  logic [SB-1:0]        ord_mem [SLOTS];
  logic                 ord_we, ord_re;
  logic [SB-1:0]        ord_waddr, ord_wdata, ord_raddr, ord_rdata_q;

  // deadline memory, repeat mark in the top bit
  logic [TIME_BITS:0]   dl_mem [SLOTS];
  logic                 dl_we, dl_re;
  logic [TIME_BITS:0]   dl_wdata, dl_rdata_q;

  logic                 accept;
  logic [3:0]           in_hin;
  logic [SW-1:0]        dl_sum;
  logic                 is_check, fire, keep, stall;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_hin        = s_axis_tdata[67:64];
  assign out_free      = !out_valid_q || m_axis_tready;

  assign dl_sum   = SW'(now_q) + SW'(delay_q);
  assign dl_wdata = {rep_q, (|dl_sum[SW-1:TIME_BITS]) ? {TIME_BITS{1'b1}}
                                                      : dl_sum[TIME_BITS-1:0]};

  // the shared comparator
  assign is_check = (cmd_q == CMD_CHECK);
  assign fire     = is_check && (dl_rdata_q[TIME_BITS-1:0] <= now_q);
  assign keep     = is_check ? !(fire && !dl_rdata_q[TIME_BITS])
                             : (ord_rdata_q != SB'(hin_q));
  assign stall    = fire && pend_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    slot_live_d  = slot_live_q;
    base_d       = base_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    scan_d       = scan_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    fin_status_d = fin_status_q;
    fin_handle_d = fin_handle_q;
    out_load     = 1'b0;
    out_status_d = STAT_FIRED;
    out_handle_d = 4'(pend_slot_q);
    out_last_d   = 1'b0;
    ord_we       = 1'b0;
    ord_waddr    = wrap_add(base_q, SB'(wr_q));
    ord_wdata    = ord_rdata_q;
    ord_re       = 1'b0;
    ord_raddr    = wrap_add(base_q, SB'(rd_q));
    dl_we        = 1'b0;
    dl_re        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d = '0;
          wr_d = '0;
          case (s_axis_tuser)
            CMD_ADD: begin
              scan_d = '0;
              if (live_q == CB'(SLOTS)) begin
                fin_status_d = STAT_FULL;
                fin_handle_d = '0;
                state_d      = ST_FIN;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_DELETE: begin
              fin_handle_d = in_hin;
              if ((32'(in_hin) < 32'(SLOTS)) && slot_live_q[SB'(in_hin)]) begin
                slot_live_d[SB'(in_hin)] = 1'b0;
                fin_status_d = STAT_DELETED;
                state_d      = ST_ORD_RD;
              end else begin
                fin_status_d = STAT_ABSENT;
                state_d      = ST_FIN;
              end
            end
            CMD_CHECK: begin
              state_d = (live_q == '0) ? ST_FIN : ST_ORD_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!slot_live_q[scan_q]) begin
          dl_we     = 1'b1;
          ord_we    = 1'b1;
          base_d    = (base_q == '0) ? SB'(SLOTS - 1) : base_q - 1'b1;
          ord_waddr = base_d;
          ord_wdata = scan_q;
          live_d    = live_q + 1'b1;
          slot_live_d[scan_q] = 1'b1;
          fin_status_d = STAT_ADDED;
          fin_handle_d = 4'(scan_q);
          state_d   = ST_FIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_ORD_RD: begin
        ord_re  = 1'b1;
        state_d = ST_DL_RD;
      end
      ST_DL_RD: begin
        dl_re   = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stall) begin
          if (fire) begin
            // the earlier fired result is now known not to be the last one
            out_load     = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_slot_d  = ord_rdata_q;
            if (!dl_rdata_q[TIME_BITS]) slot_live_d[ord_rdata_q] = 1'b0;
          end
          if (keep) begin
            ord_we = 1'b1;
            wr_d   = wr_q + 1'b1;
          end
          rd_d = rd_q + 1'b1;
          if (rd_d == live_q) begin
            live_d  = wr_d;
            state_d = ST_FIN;
          end else begin
            state_d = ST_ORD_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          if (is_check) begin
            out_status_d = pend_valid_q ? STAT_FIRED : STAT_NONE_DUE;
            out_handle_d = pend_valid_q ? 4'(pend_slot_q) : 4'd0;
          end else begin
            out_status_d = fin_status_q;
            out_handle_d = fin_handle_q;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      live_q       <= '0;
      slot_live_q  <= '0;
      base_q       <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      live_q       <= live_d;
      slot_live_q  <= slot_live_d;
      base_q       <= base_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      scan_q       <= scan_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q  <= pend_slot_d;
    fin_status_q <= fin_status_d;
    fin_handle_q <= fin_handle_d;
    if (accept) begin
      cmd_q   <= s_axis_tuser;
      now_q   <= TIME_BITS'(s_axis_tdata[31:0]);
      delay_q <= s_axis_tdata[62:32];
      rep_q   <= s_axis_tdata[63];
      hin_q   <= in_hin;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_handle_q <= out_handle_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_rdata_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) dl_mem[scan_q] <= dl_wdata;
    if (dl_re) dl_rdata_q <= dl_mem[ord_rdata_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_handle_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  `TT_ASSERT(a_live_bound, live_q <= CB'(SLOTS), "live count beyond table size")
  `TT_ASSERT_IMP(a_live_match, state_q == ST_IDLE, $countones(slot_live_q) == live_q,
                 "live count and live flags disagree")
  `TT_ASSERT_IMP(a_compact_order, state_q == ST_EVAL, wr_q <= rd_q,
                 "order write overtook read")
  `TT_ASSERT_IMP(a_pend_check, pend_valid_q, cmd_q == CMD_CHECK,
                 "pending fired result outside a check")

endmodule
